@@ hw/rtl/cartesian_polar_converter_assert.svh @@
// ----------------------------------------------------------------------------
// cartesian_polar_converter_assert.svh
// Assertion macros shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_POLAR_CONVERTER_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CPC_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("cartesian_polar_converter: assertion failed");
`define CPC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("cartesian_polar_converter: assertion failed");
`else
`define CPC_ASSERT(lbl, ck, rs, prop)
`define CPC_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

@@ hw/rtl/cpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpc_pkg
// Types, widths and the arctangent table of the CORDIC converter.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int GUARD = 4;
  localparam int CW    = 31;
  localparam int ZW    = 33;
  localparam int PW    = CW + 31;
  localparam int RSH   = 30 + GUARD;
  localparam int RW    = PW - RSH;

  localparam logic [29:0]   GAIN_Q30  = 30'h26DD3B6A;
  localparam logic [ZW-1:0] TURN_HALF = 33'h0_8000_0000;

  typedef struct packed {
    logic               polar;
    logic               zero;
    logic signed [23:0] a;
    logic signed [23:0] b;
  } cpc_tag_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cpc_vec_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/cpc_pre.sv @@
// ----------------------------------------------------------------------------
// cpc_pre
// Input stage: quadrant pre-rotation and guard-bit scaling.
// ----------------------------------------------------------------------------
module cpc_pre import cpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  logic               func,
  input  logic signed [23:0] coord_a,
  input  logic signed [23:0] coord_b,
  output logic               dn_valid,
  input  logic               dn_stall,
  output cpc_vec_t           dn_vec,
  output cpc_tag_t           dn_tag
);

  logic                 hold;
  logic signed [CW-1:0] a_g;
  logic signed [CW-1:0] b_g;
  logic                 flip;
  logic [23:0]          theta;
  cpc_vec_t             vec_next;
  cpc_tag_t             tag_next;

  assign hold     = dn_valid && dn_stall;
  assign up_stall = hold;

  always_comb begin
    a_g   = {{(CW-24){coord_a[23]}}, coord_a} <<< GUARD;
    b_g   = {{(CW-24){coord_b[23]}}, coord_b} <<< GUARD;
    flip  = coord_b[23] ^ coord_b[22];
    theta = flip ? {~coord_b[23], coord_b[22:0]} : coord_b;
    tag_next.polar = func;
    tag_next.zero  = (coord_a == 24'sd0) && (coord_b == 24'sd0);
    tag_next.a     = coord_a;
    tag_next.b     = coord_b;
    if (func) begin
      vec_next.x = flip ? -a_g : a_g;
      vec_next.y = '0;
      vec_next.z = ZW'($signed({theta, 8'h00}));
    end else if (coord_a[23]) begin
      vec_next.x = -a_g;
      vec_next.y = -b_g;
      vec_next.z = TURN_HALF;
    end else begin
      vec_next.x = a_g;
      vec_next.y = b_g;
      vec_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!hold) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      dn_vec <= vec_next;
      dn_tag <= tag_next;
    end
  end

endmodule

@@ hw/rtl/cpc_cell.sv @@
// ----------------------------------------------------------------------------
// cpc_cell
// One CORDIC micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
`include "cartesian_polar_converter_assert.svh"

module cpc_cell import cpc_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_stall,
  input  cpc_vec_t up_vec,
  input  cpc_tag_t up_tag,
  output logic     dn_valid,
  input  logic     dn_stall,
  output cpc_vec_t dn_vec,
  output cpc_tag_t dn_tag
);

  logic                 hold;
  logic                 dir_up;
  logic signed [CW-1:0] x_sh;
  logic signed [CW-1:0] y_sh;
  logic signed [ZW-1:0] at;
  cpc_vec_t             vec_next;

  assign hold     = dn_valid && dn_stall;
  assign up_stall = hold;

  always_comb begin
    x_sh   = $signed(up_vec.x) >>> STEP;
    y_sh   = $signed(up_vec.y) >>> STEP;
    at     = $signed({1'b0, atan_turn(STEP)});
    // rotation drives z to zero, vectoring drives y to zero
    dir_up = up_tag.polar ? !up_vec.z[ZW-1] : up_vec.y[CW-1];
    if (dir_up) begin
      vec_next.x = up_vec.x - y_sh;
      vec_next.y = up_vec.y + x_sh;
      vec_next.z = up_vec.z - at;
    end else begin
      vec_next.x = up_vec.x + y_sh;
      vec_next.y = up_vec.y - x_sh;
      vec_next.z = up_vec.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!hold) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      dn_vec <= vec_next;
      dn_tag <= up_tag;
    end
  end

  `CPC_ASSERT_NEXT(a_cell_advance, clk, rst, up_valid && !up_stall, dn_valid)

endmodule

@@ hw/rtl/cpc_post.sv @@
// ----------------------------------------------------------------------------
// cpc_post
// Gain correction, rounding, saturation and result register.
// ----------------------------------------------------------------------------
`include "cartesian_polar_converter_assert.svh"

module cpc_post import cpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  cpc_vec_t           up_vec,
  input  cpc_tag_t           up_tag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic signed [24:0] magnitude,
  output logic signed [23:0] angle
);

  localparam logic signed [RW-1:0] SAT_MAX = RW'(8388607);
  localparam logic signed [RW-1:0] SAT_MIN = -RW'(8388608);
  localparam logic signed [RW-1:0] MAG_MAX = RW'(16777215);
  localparam logic signed [PW-1:0] RND     = PW'(1) <<< (RSH - 1);

  logic                 hold_o;
  logic                 hold_m;
  logic                 m_valid;
  logic                 load_cart;
  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;
  logic [31:0]          m_z;
  cpc_tag_t             m_tag;

  logic signed [PW-1:0] sum_x;
  logic signed [PW-1:0] sum_y;
  logic signed [RW-1:0] rx;
  logic signed [RW-1:0] ry;
  logic signed [23:0]   sx;
  logic signed [23:0]   sy;
  logic [23:0]          mag24;
  logic [31:0]          ang_sum;
  logic signed [23:0]   pos_x_next;
  logic signed [23:0]   pos_y_next;
  logic signed [24:0]   magnitude_next;
  logic signed [23:0]   angle_next;

  function automatic logic signed [23:0] sat24(input logic signed [RW-1:0] r);
    logic signed [23:0] v;
    if (r > SAT_MAX) begin
      v = 24'sh7FFFFF;
    end else if (r < SAT_MIN) begin
      v = -24'sh800000;
    end else begin
      v = r[23:0];
    end
    return v;
  endfunction

  assign hold_o    = out_valid && out_stall;
  assign hold_m    = m_valid && hold_o;
  assign up_stall  = hold_m;
  assign load_cart = !m_tag.polar && !hold_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (!hold_m) begin
      m_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_m) begin
      prod_x <= $signed(up_vec.x) * $signed({1'b0, GAIN_Q30});
      prod_y <= $signed(up_vec.y) * $signed({1'b0, GAIN_Q30});
      m_z    <= up_vec.z[31:0];
      m_tag  <= up_tag;
    end
  end

  always_comb begin
    sum_x   = prod_x + RND;
    sum_y   = prod_y + RND;
    rx      = sum_x[PW-1:RSH];
    ry      = sum_y[PW-1:RSH];
    sx      = sat24(rx);
    sy      = sat24(ry);
    ang_sum = m_z + 32'd128;
    if (rx[RW-1]) begin
      mag24 = '0;
    end else if (rx > MAG_MAX) begin
      mag24 = 24'hFFFFFF;
    end else begin
      mag24 = rx[23:0];
    end
    if (m_tag.polar) begin
      pos_x_next     = sx;
      pos_y_next     = sy;
      magnitude_next = {m_tag.a[23], m_tag.a};
      angle_next     = m_tag.b;
    end else begin
      pos_x_next = m_tag.a;
      pos_y_next = m_tag.b;
      if (m_tag.zero) begin
        magnitude_next = '0;
        angle_next     = '0;
      end else begin
        magnitude_next = {1'b0, mag24};
        angle_next     = ang_sum[31:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold_o) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_o) begin
      pos_x     <= pos_x_next;
      pos_y     <= pos_y_next;
      magnitude <= magnitude_next;
      angle     <= angle_next;
    end
  end

  `CPC_ASSERT_NEXT(a_post_advance, clk, rst, m_valid && !hold_m && !hold_o, out_valid)
  `CPC_ASSERT(a_post_mag_sign, clk, rst, (out_valid && $past(load_cart)) |-> !magnitude[24])

endmodule

@@ hw/rtl/cartesian_polar_converter.sv @@
// ----------------------------------------------------------------------------
// cartesian_polar_converter
// Pipelined CORDIC converting a vector between cartesian and polar form.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall with func, coord_a and coord_b; each
// request yields one result on out_valid/out_stall carrying pos_x, pos_y,
// magnitude and angle. func low: coord_a/coord_b are x/y (vectoring);
// func high: they are r/theta (rotation). The given pair is echoed back.
// Throughput: one request per clock cycle while in_stall is low.
// A request passes CORDIC_STEPS + 3 registers: one input stage, one cell per
// CORDIC step, one gain multiply stage, one result register. The length of
// the cell chain sets this figure.
// Reset clears every stage valid; no request is in flight afterwards.
// When the receiver stalls the result register holds; the stall ripples
// back only through occupied stages, so empty slots keep filling and
// in_stall rises only once every stage holds a request.
// ----------------------------------------------------------------------------
`include "cartesian_polar_converter_assert.svh"

module cartesian_polar_converter import cpc_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [23:0] coord_a,
  input  logic signed [23:0] coord_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic signed [24:0] magnitude,
  output logic signed [23:0] angle
);

  logic     chain_valid [0:CORDIC_STEPS];
  logic     chain_stall [0:CORDIC_STEPS];
  cpc_vec_t chain_vec   [0:CORDIC_STEPS];
  cpc_tag_t chain_tag   [0:CORDIC_STEPS];

  cpc_pre u_pre (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .func     (func),
    .coord_a  (coord_a),
    .coord_b  (coord_b),
    .dn_valid (chain_valid[0]),
    .dn_stall (chain_stall[0]),
    .dn_vec   (chain_vec[0]),
    .dn_tag   (chain_tag[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    cpc_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_stall (chain_stall[i]),
      .up_vec   (chain_vec[i]),
      .up_tag   (chain_tag[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_stall (chain_stall[i+1]),
      .dn_vec   (chain_vec[i+1]),
      .dn_tag   (chain_tag[i+1])
    );
  end

  cpc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (chain_valid[CORDIC_STEPS]),
    .up_stall  (chain_stall[CORDIC_STEPS]),
    .up_vec    (chain_vec[CORDIC_STEPS]),
    .up_tag    (chain_tag[CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .magnitude (magnitude),
    .angle     (angle)
  );

  `CPC_ASSERT(a_stall_source, clk, rst, in_stall |-> (out_valid && out_stall))
  `CPC_ASSERT(a_stall_free, clk, rst, !(out_valid && out_stall) |-> !in_stall)

endmodule
